>>> design/lzce_pkg.sv
// Shared types, constants and helper functions for the LoG zero-crossing edge block.
package lzce_pkg;

    localparam int PIX_W     = 8;
    localparam int COEFF_W   = 16;
    localparam int NUM_COEFF = 15;
    localparam int NUM_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int PROD_W    = PIX_W + 1 + COEFF_W;
    localparam int ACC_W     = 32;
    localparam int ROW_W     = 16;
    localparam int IMG_W_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int OQ_DEPTH  = 16;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_3      = 3'd5;

    // Per-item classification made at accept time.
    typedef struct packed {
        logic comp;  // a Laplacian value is produced
        logic emit;  // an edge result is produced
        logic last;  // final result of the frame
    } t_tag;

    typedef struct packed {
        logic neg;
        logic pos;
    } t_sign;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             last;
    } t_result;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_coeff_words;

    // Coefficient slot for tap offset (dr, dc) around the kernel center.
    function automatic logic [3:0] coeff_index(input int dr, input int dc, input int half);
        int a;
        int b;
        int t;
        a = (dr < 0) ? -dr : dr;
        b = (dc < 0) ? -dc : dc;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        return 4'(a * (half + 1) - (a * (a - 1)) / 2 + (b - a));
    endfunction

    function automatic logic opposite(input t_sign a, input t_sign b);
        return (a.neg & b.pos) | (a.pos & b.neg);
    endfunction

endpackage

>>> design/lzce_front.sv
// Front end: raster counters, item classification, pixel column store and 9x9 window.
module lzce_front import lzce_pkg::*; #(
    parameter int KERNEL_SIZE = 9,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_accept,
    input  logic [PIX_W-1:0]                         i_pixel,
    input  logic [$clog2(MAX_WIDTH):0]               i_eff_w,
    input  logic [ROW_W-1:0]                         i_eff_h,
    output logic                                     o_emit_now,
    output logic                                     o_win_valid,
    output t_tag                                     o_win_tag,
    output logic [$clog2(MAX_WIDTH)-1:0]             o_win_lx,
    output logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] o_window
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int K     = KERNEL_SIZE;
    localparam int COL_W = K * PIX_W;
    localparam int MEM_W = (K - 1) * PIX_W;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW:0]      col_inc;
    logic [ROW_W:0]   row_inc;
    t_tag             tag_now;

    logic [MEM_W-1:0] r_mem [MAX_WIDTH];
    logic [MEM_W-1:0] r_rd;
    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [CW-1:0]    r_s1_lx;
    t_tag             r_s1_tag;
    logic [COL_W-1:0] full_col;
    logic [COL_W-1:0] r_win [K];
    logic             r_s2_v;
    t_tag             r_s2_tag;
    logic [CW-1:0]    r_s2_lx;

    always_comb begin
        col_inc = {1'b0, r_col} + 1'b1;
        row_inc = {1'b0, r_row} + 1'b1;
        n_col   = r_col;
        n_row   = r_row;
        if (col_inc >= i_eff_w) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, i_eff_h}) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
        tag_now.comp = (r_row >= ROW_W'(K - 1)) && (r_col >= CW'(K - 1));
        tag_now.emit = (r_row >= ROW_W'(K + 1)) && (r_col >= CW'(K + 1));
        tag_now.last = (r_row == i_eff_h - 1'b1) && ({1'b0, r_col} == i_eff_w - 1'b1);
    end

    assign o_emit_now = tag_now.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_v <= i_accept;
            r_s2_v <= r_s1_v;
        end
    end

    // Column store: each entry holds the K-1 older pixels of one column, oldest low.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd <= r_mem[r_col];
        end
        if (r_s1_v) begin
            r_mem[r_s1_col] <= full_col[COL_W-1:PIX_W];
        end
    end

    assign full_col = {r_s1_pix, r_rd};

    always_ff @(posedge i_clk) begin
        r_s1_pix <= i_pixel;
        r_s1_col <= r_col;
        r_s1_lx  <= r_col - CW'(K - 1);
        r_s1_tag <= tag_now;
        if (r_s1_v) begin
            for (int i = 0; i < K - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[K-1] <= full_col;
        end
        r_s2_tag <= r_s1_tag;
        r_s2_lx  <= r_s1_lx;
    end

    always_comb begin
        for (int i = 0; i < K; i++) begin
            o_window[i*COL_W +: COL_W] = r_win[i];
        end
    end

    assign o_win_valid = r_s2_v;
    assign o_win_tag   = r_s2_tag;
    assign o_win_lx    = r_s2_lx;

endmodule

>>> design/lzce_conv.sv
// Back end, part one: LoG convolution lanes, registered adder tree and sign of the sum.
module lzce_conv import lzce_pkg::*; #(
    parameter int KERNEL_SIZE = 9,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  t_tag                                     i_tag,
    input  logic [$clog2(MAX_WIDTH)-1:0]             i_lx,
    input  logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] i_window,
    input  t_coeff_words                             i_coeff,
    output logic                                     o_valid,
    output t_tag                                     o_tag,
    output logic [$clog2(MAX_WIDTH)-1:0]             o_lx,
    output t_sign                                    o_sign
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int K    = KERNEL_SIZE;
    localparam int HALF = KERNEL_SIZE / 2;

    logic signed [COEFF_W-1:0] coef [NUM_COEFF];
    logic signed [PROD_W-1:0]  r_prod [K][K];
    logic signed [ACC_W-1:0]   row_sum [K];
    logic signed [ACC_W-1:0]   r_row_sum [K];
    logic signed [ACC_W-1:0]   total;
    logic [2:0]                r_v;
    t_tag                      r_tag [3];
    logic [CW-1:0]             r_lx [3];
    t_sign                     r_sign;

    always_comb begin
        for (int n = 0; n < NUM_COEFF; n++) begin
            coef[n] = i_coeff[n / 4][16 * (n % 4) +: COEFF_W];
        end
    end

    // Widen both operands first so the product keeps its full width.
    always_ff @(posedge i_clk) begin
        for (int dr = 0; dr < K; dr++) begin
            for (int dc = 0; dc < K; dc++) begin
                r_prod[dr][dc] <=
                    PROD_W'($signed({1'b0, i_window[(dc*K + dr)*PIX_W +: PIX_W]}))
                    * PROD_W'(coef[coeff_index(dr - HALF, dc - HALF, HALF)]);
            end
        end
    end

    always_comb begin
        for (int dr = 0; dr < K; dr++) begin
            row_sum[dr] = '0;
            for (int dc = 0; dc < K; dc++) begin
                row_sum[dr] = row_sum[dr] + ACC_W'(r_prod[dr][dc]);
            end
        end
        total = '0;
        for (int dr = 0; dr < K; dr++) begin
            total = total + r_row_sum[dr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_sum <= row_sum;
        r_sign.neg <= total < 0;
        r_sign.pos <= total > 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_lx[0]  <= i_lx;
        for (int i = 1; i < 3; i++) begin
            r_tag[i] <= r_tag[i-1];
            r_lx[i]  <= r_lx[i-1];
        end
    end

    assign o_valid = r_v[2];
    assign o_tag   = r_tag[2];
    assign o_lx    = r_lx[2];
    assign o_sign  = r_sign;

endmodule

>>> design/lzce_zcross.sv
// Back end, part two: Laplacian sign column store, 3x3 sign window and zero-crossing test.
module lzce_zcross import lzce_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_tag                         i_tag,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_lx,
    input  t_sign                        i_sign,
    output logic                         o_push,
    output t_result                      o_result
);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [1:0][1:0]  r_mem [MAX_WIDTH];
    logic [1:0][1:0]  r_rd;
    logic             r_z1_v;
    t_tag             r_z1_tag;
    logic [CW-1:0]    r_z1_lx;
    t_sign            r_z1_sign;
    logic [2:0][1:0]  full_col;
    logic [2:0][1:0]  r_win [3];
    logic             r_z2_v;
    t_tag             r_z2_tag;
    logic             edge_hit;

    // Only items that produce a Laplacian value touch this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1_v <= 1'b0;
            r_z2_v <= 1'b0;
        end else begin
            r_z1_v <= i_valid & i_tag.comp;
            r_z2_v <= r_z1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_tag.comp) begin
            r_rd <= r_mem[i_lx];
        end
        if (r_z1_v) begin
            r_mem[r_z1_lx] <= full_col[2:1];
        end
    end

    assign full_col = {r_z1_sign, r_rd};

    always_ff @(posedge i_clk) begin
        r_z1_tag  <= i_tag;
        r_z1_lx   <= i_lx;
        r_z1_sign <= i_sign;
        r_z2_tag  <= r_z1_tag;
        if (r_z1_v) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= full_col;
        end
    end

    // Rows: index 0 top, 1 middle, 2 bottom. Columns: window slot 1 is the center.
    always_comb begin
        edge_hit = opposite(r_win[1][0], r_win[1][2]) ||
                   opposite(r_win[0][1], r_win[2][1]) ||
                   opposite(r_win[0][2], r_win[2][0]) ||
                   opposite(r_win[0][0], r_win[2][2]);
        o_result.edge_res = edge_hit ? EDGE_ON : EDGE_OFF;
        o_result.last     = r_z2_tag.last;
    end

    assign o_push = r_z2_v & r_z2_tag.emit;

endmodule

>>> design/lzce_outq.sv
// Result queue with reservation count: a slot is held from accept until the beat is popped.
module lzce_outq import lzce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_reserve,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_data
);
    localparam int CNT_W = OQ_PTR_W + 1;

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_used;
    logic                do_pop;

    assign do_pop  = i_pop & ~o_empty;
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_used == CNT_W'(OQ_DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt  <= r_cnt + CNT_W'(i_push) - CNT_W'(do_pop);
            r_used <= r_used + CNT_W'(i_reserve) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> design/log_zero_crossing_edge.sv
// LoG zero-crossing edge detector, top level.
// Input channel: drive i_pixel and raise push; a beat is taken at a clock edge with
// push high and full low. Pixels come in raster order, one row of image_width pixels
// after another, image_height rows per frame.
// Result channel: while empty is low, o_edge_res (255 or 0) and o_frame_last show the
// oldest result; raise pop to take it. One result per interior Laplacian position;
// the one-pixel zero border is left to the consumer.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we high
// (0 width, 1 height, 2..5 coefficient words), only while the block is idle.
// Throughput: one pixel per clock while full is low. A result passes through the
// window, multiply lanes, two adder levels, sign column store, sign window and queue
// write after the pixel that completes its neighborhood is taken.
// Stall: each result holds a queue slot from accept on; when 16 slots are held,
// full rises and stays until pop frees one, so nothing in the pipeline ever waits.
// Reset: counters and queue clear, width and height return to 1024, coefficients
// to zero; line stores are not cleared.
module log_zero_crossing_edge import lzce_pkg::*; #(
    parameter int KERNEL_SIZE = 9,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     o_edge_res,
    output logic                 o_frame_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [IMG_W_W-1:0] r_image_width;
    logic [ROW_W-1:0]   r_image_height;
    t_coeff_words       r_coeff;
    logic [CW:0]        eff_w;
    logic [ROW_W-1:0]   eff_h;
    logic               accept;
    logic               emit_now;

    logic                              win_valid;
    t_tag                              win_tag;
    logic [CW-1:0]                     win_lx;
    logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] window;
    logic                              lap_valid;
    t_tag                              lap_tag;
    logic [CW-1:0]                     lap_lx;
    t_sign                             lap_sign;
    logic                              res_push;
    t_result                           res_data;
    t_result                           q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMG_W_W'(1024);
            r_image_height <= ROW_W'(1024);
            r_coeff        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                REG_COEFF_0:      r_coeff[0]     <= i_cfg_data;
                REG_COEFF_1:      r_coeff[1]     <= i_cfg_data;
                REG_COEFF_2:      r_coeff[2]     <= i_cfg_data;
                REG_COEFF_3:      r_coeff[3]     <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp frame size to what the kernel and the line stores support.
    always_comb begin
        if (32'(r_image_width) < 32'(KERNEL_SIZE + 2)) begin
            eff_w = (CW+1)'(KERNEL_SIZE + 2);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end else begin
            eff_w = (CW+1)'(r_image_width);
        end
        if (32'(r_image_height) < 32'(KERNEL_SIZE + 2)) begin
            eff_h = ROW_W'(KERNEL_SIZE + 2);
        end else begin
            eff_h = r_image_height;
        end
    end

    assign accept = push & ~full;

    lzce_front #(
        .KERNEL_SIZE(KERNEL_SIZE),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pixel    (i_pixel),
        .i_eff_w    (eff_w),
        .i_eff_h    (eff_h),
        .o_emit_now (emit_now),
        .o_win_valid(win_valid),
        .o_win_tag  (win_tag),
        .o_win_lx   (win_lx),
        .o_window   (window)
    );

    lzce_conv #(
        .KERNEL_SIZE(KERNEL_SIZE),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .i_tag   (win_tag),
        .i_lx    (win_lx),
        .i_window(window),
        .i_coeff (r_coeff),
        .o_valid (lap_valid),
        .o_tag   (lap_tag),
        .o_lx    (lap_lx),
        .o_sign  (lap_sign)
    );

    lzce_zcross #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_zcross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lap_valid),
        .i_tag   (lap_tag),
        .i_lx    (lap_lx),
        .i_sign  (lap_sign),
        .o_push  (res_push),
        .o_result(res_data)
    );

    lzce_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_reserve(accept & emit_now),
        .i_push   (res_push),
        .i_data   (res_data),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_data   (q_data)
    );

    assign o_edge_res   = q_data.edge_res;
    assign o_frame_last = q_data.last;

endmodule

>>> design/lzce_checker.sv
// Port-level checker for the edge detector and its bind to the top level.
module lzce_assert import lzce_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [PIX_W-1:0] o_edge_res,
    input logic             o_frame_last
);

    // Reset drops all queued results.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset releases all reserved slots.
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    // A result is a binary edge map value.
    a_edge_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_edge_res == EDGE_ON || o_edge_res == EDGE_OFF))
        else $error("edge result neither 0 nor 255");

    // Hold the waiting beat while it is not taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_edge_res) && $stable(o_frame_last))
        else $error("waiting result changed before pop");

endmodule

bind log_zero_crossing_edge lzce_assert u_lzce_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_edge_res  (o_edge_res),
    .o_frame_last(o_frame_last)
);

>>> tb/lzce_checker.sv
// Scoreboard for the LoG zero-crossing edge block: shadow state, edge prediction, compare.
`timescale 1ns / 1ps

module lzce_checker import lzce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [PIX_W-1:0]     i_edge_res,
    input  logic                 i_frame_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int KS   = 9;
    localparam int HK   = KS / 2;
    localparam int MAXW = 1024;

    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [WORD_W-1:0]  kernel_words [NUM_WORDS];
    logic [PIX_W-1:0]   pix_rows [KS][MAXW];
    int                 lap_rows [3][MAXW];
    int unsigned        col_pos;
    int unsigned        row_pos;
    t_result            edge_q [$];
    int                 fails = 0;

    function automatic int tap_weight(int dr, int dc);
        int a;
        int b;
        int t;
        int n;
        logic [COEFF_W-1:0] raw;
        a = (dr < 0) ? -dr : dr;
        b = (dc < 0) ? -dc : dc;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        n   = a * (HK + 1) - (a * (a - 1)) / 2 + (b - a);
        raw = kernel_words[n / 4][16 * (n % 4) +: 16];
        return int'($signed(raw));
    endfunction

    function automatic bit sign_flip(int a, int b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // Shadow one pixel beat; queue an edge result when the window completes one.
    task automatic take_pixel(logic [PIX_W-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ly;
        int unsigned lx;
        int unsigned x;
        int unsigned slot;
        int unsigned t_row;
        int unsigned m_row;
        int unsigned b_row;
        longint      acc;
        t_result     res;
        w = width_reg;
        h = height_reg;
        if (w < KS + 2) w = KS + 2;
        if (w > MAXW) w = MAXW;
        if (h < KS + 2) h = KS + 2;
        c = col_pos % MAXW;
        r = row_pos;
        pix_rows[r % KS][c] = p;
        if (r >= KS - 1 && c >= KS - 1) begin
            ly  = r - (KS - 1);
            lx  = c - (KS - 1);
            acc = 0;
            for (int dr = 0; dr < KS; dr++) begin
                slot = (r + 1 + dr) % KS;
                for (int dc = 0; dc < KS; dc++)
                    acc += longint'(pix_rows[slot][lx + dc]) * tap_weight(dr - HK, dc - HK);
            end
            lap_rows[ly % 3][lx] = int'(acc);
            if (ly >= 2 && lx >= 2) begin
                t_row = (ly + 1) % 3;
                m_row = (ly + 2) % 3;
                b_row = ly % 3;
                x     = lx - 1;
                res.edge_res =
                    (sign_flip(lap_rows[t_row][x], lap_rows[b_row][x]) ||
                     sign_flip(lap_rows[m_row][x-1], lap_rows[m_row][x+1]) ||
                     sign_flip(lap_rows[b_row][x-1], lap_rows[t_row][x+1]) ||
                     sign_flip(lap_rows[t_row][x-1], lap_rows[b_row][x+1]))
                    ? EDGE_ON : EDGE_OFF;
                res.last = (r == h - 1 && c == w - 1);
                edge_q.push_back(res);
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg  = 11'd1024;
            height_reg = 16'd1024;
            for (int i = 0; i < NUM_WORDS; i++) kernel_words[i] = '0;
            col_pos = 0;
            row_pos = 0;
            edge_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  width_reg = i_cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = i_cfg_data[ROW_W-1:0];
                    REG_COEFF_0:      kernel_words[0] = i_cfg_data;
                    REG_COEFF_1:      kernel_words[1] = i_cfg_data;
                    REG_COEFF_2:      kernel_words[2] = i_cfg_data;
                    REG_COEFF_3:      kernel_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) take_pixel(i_pixel);
            if (i_pop && !i_empty) begin
                if (edge_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected beat: got edge=%0d last=%0d",
                             $time, i_edge_res, i_frame_last);
                end else begin
                    want = edge_q.pop_front();
                    if (want.edge_res !== i_edge_res || want.last !== i_frame_last) begin
                        fails++;
                        $display("%0t mismatch: expected edge=%0d last=%0d got edge=%0d last=%0d",
                                 $time, want.edge_res, want.last, i_edge_res, i_frame_last);
                    end
                end
            end
        end
        o_pending    <= edge_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the LoG zero-crossing edge block.
`timescale 1ns / 1ps

module tb_top;
    import lzce_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [PIX_W-1:0]     o_edge_res;
    logic                 o_frame_last;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    int                   fail_count;
    int                   pending;
    int                   burst_left = 0;
    bit                   hold_req = 0;
    logic [WORD_W-1:0]    kernel_set [NUM_WORDS];

    always #5 i_clk = ~i_clk;

    log_zero_crossing_edge u_top (.*);

    lzce_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_pixel(i_pixel), .i_empty(empty), .i_pop(pop), .i_edge_res(o_edge_res),
        .i_frame_last(o_frame_last), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #5ms;
        $display("[log_zero_crossing_edge] ERROR");
        $finish;
    end

    // Receiver: rotating stall pattern, plus one long hold on request.
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                // Start the hold once results are flowing
                while (empty) @(posedge i_clk);
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else begin
                case ((cyc / 64) % 4)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    2: pop <= ($urandom_range(0, 9) != 0);
                    default: pop <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
                cyc++;
            end
        end
    end

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write every register from one setting; block must be idle.
    task automatic configure(logic [WORD_W-1:0] w_val, logic [WORD_W-1:0] h_val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_IMAGE_WIDTH;  i_cfg_data <= w_val;         @(posedge i_clk);
        i_cfg_idx <= REG_IMAGE_HEIGHT; i_cfg_data <= h_val;         @(posedge i_clk);
        i_cfg_idx <= REG_COEFF_0;      i_cfg_data <= kernel_set[0]; @(posedge i_clk);
        i_cfg_idx <= REG_COEFF_1;      i_cfg_data <= kernel_set[1]; @(posedge i_clk);
        i_cfg_idx <= REG_COEFF_2;      i_cfg_data <= kernel_set[2]; @(posedge i_clk);
        i_cfg_idx <= REG_COEFF_3;      i_cfg_data <= kernel_set[3]; @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_kernel(int kind);
        for (int i = 0; i < NUM_WORDS; i++) begin
            case (kind)
                0: kernel_set[i] = '0;
                1: kernel_set[i] = {4{16'h7fff}};
                2: kernel_set[i] = {4{16'h8000}};
                3: kernel_set[i] = (i == 0) ? {{3{16'h8000}}, 16'h7fff} : {4{16'h8000}};
                4: kernel_set[i] = {4{16'hffff}};
                // Center-positive, negative surround, like a LoG
                5: kernel_set[i] = (i == 0) ? {16'hffe0, 16'hffc0, 16'hff80, 16'h2000}
                                            : {4{16'($urandom_range(0, 255)) ^ 16'hffff}};
                default: kernel_set[i] = {$urandom, $urandom};
            endcase
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style, int r, int c);
        case (style)
            0: return PIX_W'($urandom);
            1: return ((((r >> 1) + (c >> 1)) & 1) != 0) ? 8'd255 : 8'd0;
            2: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            default: return PIX_W'(r * 20 + c * 7 + $urandom_range(0, 3));
        endcase
    endfunction

    // Offer one pixel beat; bursts of random length, random gaps between them.
    task automatic send_pixel(logic [PIX_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push    <= 1'b1;
        i_pixel <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_frames(int w, int h, int frames, int style);
        for (int f = 0; f < frames; f++)
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    send_pixel(pick_pixel(style, r, c));
    endtask

    initial begin
        int rand_items;
        int w;
        int h;
        int frames;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame, extreme pixels, extreme kernels
        pick_kernel(3);
        configure(64'd11, 64'd65535);
        configure(64'd11, 64'd11);
        send_frames(11, 11, 1, 1);
        drain();
        pick_kernel(1);
        configure(64'd0, 64'd0);
        send_frames(11, 11, 1, 2);
        drain();

        // Undersized height value; long receiver hold fills the queue
        pick_kernel(5);
        configure(64'd28, 64'd10);
        hold_req = 1;
        send_frames(28, 11, 1, 0);
        drain();

        rand_items = 0;
        while (rand_items < 150) begin
            w      = $urandom_range(11, 16);
            h      = $urandom_range(11, 13);
            frames = 1;
            pick_kernel($urandom_range(0, 9));
            configure(64'(w), 64'(h));
            send_frames(w, h, frames, $urandom_range(0, 3));
            rand_items += w * h * frames;
            if ($urandom_range(0, 1) == 1) begin
                // Occasionally pause mid-phase until everything has come back
                push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                send_frames(w, h, 1, $urandom_range(0, 3));
                rand_items += w * h;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[log_zero_crossing_edge] OK");
        end else begin
            $display("[log_zero_crossing_edge] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/lzce_pkg.sv
design/lzce_front.sv
design/lzce_conv.sv
design/lzce_zcross.sv
design/lzce_outq.sv
design/log_zero_crossing_edge.sv
design/lzce_checker.sv
tb/lzce_checker.sv
tb/tb_top.sv
